>>> hdl/sle_pkg.sv
`timescale 1ns / 1ps

package sle_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 32;

  typedef enum logic [2:0] {
    K_APPEND = 3'd0,
    K_RM_HEAD = 3'd1,
    K_RM_TAIL = 3'd2,
    K_RM_VALUE = 3'd3,
    K_SEARCH = 3'd4,
    K_MAXIMUM = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

>>> hdl/sle_cell.sv
`timescale 1ns / 1ps

module sle_cell #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  sle_pkg::cell_ctl_t                 ctl,
  input  logic [$clog2(CAPACITY)-1:0]        wr_idx,
  input  logic [sle_pkg::VALUE_W-1:0]        wr_data,
  input  logic [sle_pkg::VALUE_W-1:0]        right_in,
  output logic [sle_pkg::VALUE_W-1:0]        value_out
);
  import sle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VALUE_W-1:0] value_r;

  always_ff @(posedge clk) begin
    if (ctl.wr && (wr_idx == MY_IDX)) begin
      value_r <= wr_data;
    end else if (ctl.shift) begin
      value_r <= right_in;
    end
  end

  assign value_out = value_r;

endmodule

>>> hdl/sequence_list_engine.sv
`timescale 1ns / 1ps
// Append, and any request on an empty list or with an unused kind: accept goes straight to S_DONE.
// Remove head/tail/value, search and maximum: the stored entries rotate once through the cell
// ring, one entry per cycle past the head cell, and then S_DONE registers the result.
// One request at a time; the next is taken the cycle after the result is registered.
// Synchronous active-low reset empties the list; cell contents are not cleared.
module sequence_list_engine #(
  parameter int CAPACITY = sle_pkg::DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] operand
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [1:0]  out_tuser   // [1:0] status
);
  import sle_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  state_t              state_r;
  kind_t               kind_r;
  logic [VALUE_W-1:0]  op_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       n0_r;
  logic [CW-1:0]       step_r;
  logic                found_r;
  logic signed [VALUE_W-1:0] max_r;
  logic [VALUE_W-1:0]  res_value_r;
  status_t             res_status_r;
  logic                out_tvalid_r;
  logic [VALUE_W-1:0]  out_data_r;
  status_t             out_status_r;

  logic [VALUE_W-1:0]  cell_val [CAPACITY];
  logic [VALUE_W-1:0]  head;
  logic                walking;
  logic                hit;
  logic                last_step;
  logic                drop;
  logic                found_nxt;
  logic signed [VALUE_W-1:0] max_nxt;
  logic [CW-1:0]       cnt_dec;
  logic                accept;
  kind_t               kind_in;
  logic                append_wr;
  cell_ctl_t           ctl;
  logic [IW-1:0]       wr_idx;
  logic [VALUE_W-1:0]  wr_data;

  assign head      = cell_val[0];
  assign walking   = (state_r == S_WALK);
  assign hit       = (head == op_r);
  assign cnt_dec   = count_r - CW'(1);
  assign last_step = (step_r == (n0_r - CW'(1)));
  assign accept    = in_tvalid && in_tready;
  assign kind_in   = kind_t'(in_tuser);
  assign append_wr = accept && (kind_in == K_APPEND) && (count_r < CW'(CAPACITY));

  always_comb begin
    case (kind_r)
      K_RM_HEAD:  drop = (step_r == '0);
      K_RM_TAIL:  drop = last_step;
      K_RM_VALUE: drop = !found_r && hit;
      default:    drop = 1'b0;
    endcase
    found_nxt = found_r || hit;
    if ((step_r == '0) || ($signed(head) > max_r)) begin
      max_nxt = $signed(head);
    end else begin
      max_nxt = max_r;
    end
  end

  assign ctl.shift = walking;
  assign ctl.wr    = append_wr || (walking && !drop);
  assign wr_idx    = walking ? cnt_dec[IW-1:0] : count_r[IW-1:0];
  assign wr_data   = walking ? head : in_tdata;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_W-1:0] right_val;
    if (g == CAPACITY - 1) begin : g_wrap
      assign right_val = head;
    end else begin : g_link
      assign right_val = cell_val[g+1];
    end
    sle_cell #(
      .CAPACITY(CAPACITY),
      .IDX(g)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .wr_idx(wr_idx),
      .wr_data(wr_data),
      .right_in(right_val),
      .value_out(cell_val[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r       <= kind_in;
            op_r         <= in_tdata;
            step_r       <= '0;
            n0_r         <= count_r;
            found_r      <= 1'b0;
            res_value_r  <= '0;
            case (kind_in) inside
              K_APPEND: begin
                state_r <= S_DONE;
                if (count_r >= CW'(CAPACITY)) begin
                  res_status_r <= ST_FULL;
                end else begin
                  res_status_r <= ST_OK;
                  count_r      <= count_r + CW'(1);
                end
              end
              K_RM_HEAD, K_RM_TAIL, K_RM_VALUE, K_SEARCH, K_MAXIMUM: begin
                if (count_r == '0) begin
                  res_status_r <= ST_EMPTY;
                  state_r      <= S_DONE;
                end else begin
                  res_status_r <= ST_OK;
                  state_r      <= S_WALK;
                end
              end
              default: begin
                res_status_r <= ST_OK;
                state_r      <= S_DONE;
              end
            endcase
          end
        end
        S_WALK: begin
          step_r  <= step_r + CW'(1);
          found_r <= found_nxt;
          max_r   <= max_nxt;
          if (drop) begin
            count_r <= cnt_dec;
          end
          if (drop && ((kind_r == K_RM_HEAD) || (kind_r == K_RM_TAIL))) begin
            res_value_r <= head;
          end
          if (last_step) begin
            state_r <= S_DONE;
            if ((kind_r inside {K_RM_VALUE, K_SEARCH}) && !found_nxt) begin
              res_status_r <= ST_NOT_FOUND;
            end else begin
              res_status_r <= ST_OK;
            end
            if (kind_r == K_MAXIMUM) begin
              res_value_r <= max_nxt;
            end
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= res_value_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (kind_in == K_APPEND) && (count_r == CW'(CAPACITY)))
      |=> (res_status_r == ST_FULL) && (count_r == CW'(CAPACITY)))
    else $error("append to full list not rejected");

  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    walking |-> (step_r < n0_r))
    else $error("walk ran past stored entries");

  a_walk_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    (walking && last_step) |=> (state_r == S_DONE)
      && ((count_r == n0_r) || (count_r == (n0_r - CW'(1)))))
    else $error("walk changed count by more than one");
`endif

endmodule

>>> tb/sv/sequence_list_engine_tb.sv
`timescale 1ns / 1ps

module sequence_list_engine_tb;
  import sle_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [31:0]  stored_values[$];
  list_result_t awaited_results[$];
  int           mismatch_count = 0;
  bit           idle_enabled = 1'b1;

  sequence_list_engine #(.CAPACITY(CAPACITY)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  task automatic apply_list_request(input logic [2:0] kind, input logic [31:0] operand);
    list_result_t res;
    int hit;
    res.value  = '0;
    res.status = ST_OK;
    hit = -1;
    case (kind)
      K_APPEND: begin
        if (stored_values.size() >= CAPACITY) res.status = ST_FULL;
        else stored_values.push_back(operand);
      end
      K_RM_HEAD: begin
        if (stored_values.size() == 0) res.status = ST_EMPTY;
        else res.value = stored_values.pop_front();
      end
      K_RM_TAIL: begin
        if (stored_values.size() == 0) res.status = ST_EMPTY;
        else res.value = stored_values.pop_back();
      end
      K_RM_VALUE, K_SEARCH: begin
        if (stored_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          foreach (stored_values[i])
            if (hit < 0 && stored_values[i] == operand) hit = i;
          if (hit < 0) res.status = ST_NOT_FOUND;
          else if (kind == K_RM_VALUE) stored_values.delete(hit);
        end
      end
      K_MAXIMUM: begin
        if (stored_values.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.value = stored_values[0];
          foreach (stored_values[i])
            if ($signed(stored_values[i]) > $signed(res.value)) res.value = stored_values[i];
        end
      end
      default: ;
    endcase
    awaited_results.push_back(res);
  endtask

  task automatic send_request(input logic [2:0] kind, input logic [31:0] operand);
    if (idle_enabled) begin
      while ($urandom_range(99) < 26) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= operand;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_list_request(kind, operand);
  endtask

  function automatic logic [31:0] pick_operand(input bit prefer_stored);
    int sel;
    sel = $urandom_range(99);
    if (prefer_stored && stored_values.size() != 0 && sel < 60)
      return stored_values[$urandom_range(stored_values.size() - 1)];
    if (sel < 78) return $urandom_range(8) - 4;
    if (sel < 86) return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    return $urandom();
  endfunction

  task automatic test_empty_requests();
    send_request(K_RM_HEAD, 32'h0000_0001);
    send_request(K_RM_TAIL, 32'h0000_0002);
    send_request(K_RM_VALUE, 32'h0000_0000);
    send_request(K_SEARCH, 32'hffff_ffff);
    send_request(K_MAXIMUM, 32'h0000_0000);
  endtask

  task automatic test_unused_kinds();
    send_request(KIND_UNUSED_LO, 32'hffff_ffff);
    send_request(KIND_UNUSED_HI, 32'h5555_aaaa);
  endtask

  task automatic test_single_entry();
    send_request(K_APPEND, 32'h8000_0000);
    send_request(K_RM_HEAD, 32'h0000_0000);
  endtask

  task automatic test_fill_and_probe();
    logic [31:0] v;
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) v = 32'h8000_0000;
      else if (i == 9) v = 32'h7fff_ffff;
      else if (i == CAPACITY - 1) v = 32'hffff_ffff;
      else v = i * 7;
      send_request(K_APPEND, v);
    end
    send_request(K_APPEND, 32'h0000_0042);
    send_request(K_MAXIMUM, 32'h0000_0000);
    send_request(K_SEARCH, 32'h0000_0003);
    send_request(K_RM_VALUE, 32'h0000_0003);
  endtask

  task automatic test_random_traffic(input int count);
    int   done;
    int   roll;
    bit   filling;
    logic [2:0] kind;
    done    = 0;
    filling = 1'b1;
    while (done < count) begin
      if (stored_values.size() == 0) filling = 1'b1;
      else if (stored_values.size() == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      else if ($urandom_range(29) == 0) filling = ~filling;
      roll = $urandom_range(99);
      if (roll < 2) kind = (roll != 0) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
      else if (roll < (filling ? 60 : 18)) kind = K_APPEND;
      else kind = 3'($urandom_range(5, 1));
      send_request(kind, pick_operand(kind != K_APPEND));
      if (kind != KIND_UNUSED_LO && kind != KIND_UNUSED_HI) done++;
    end
  endtask

  task automatic test_steady_stream(input int count);
    idle_enabled = 1'b0;
    test_random_traffic(count);
    idle_enabled = 1'b1;
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value=%h status=%0d", out_tdata, out_tuser);
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                     want.value, want.status, out_tdata, out_tuser);
        end
      end
    end
    out_tready <= idle_enabled ? ($urandom_range(99) >= 26) : 1'b1;
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_requests();
    test_unused_kinds();
    test_single_entry();
    test_fill_and_probe();
    test_random_traffic(400);
    test_steady_stream(200);
    test_random_traffic(400);

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (awaited_results.size() != 0) mismatch_count++;

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sequence_list_engine.f
hdl/sle_pkg.sv
hdl/sle_cell.sv
hdl/sequence_list_engine.sv
tb/sv/sequence_list_engine_tb.sv
